// File: rtl/tdpt_pkg.sv
// Shared types and constants for the trial-division prime test.
`timescale 1ns / 1ps
`default_nettype none
package tdpt_pkg;

  // Width of the candidate field on the input stream
  localparam int CAND_WIDTH = 16;
  // Result stream tdata width (is_prime padded to one byte)
  localparam int OUT_TDATA_W = 8;

  // Request into the shared remainder unit
  typedef struct packed {
    logic start;
  } rem_ctl_t;

  // Status back from the remainder unit
  typedef struct packed {
    logic busy;
    logic done;   // one-cycle pulse, remainder valid
    logic zero;   // remainder is zero (valid with done)
  } rem_sts_t;

endpackage
`default_nettype wire

// File: rtl/tdpt_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tdpt_rem
  import tdpt_pkg::*;
#(
  parameter int W = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire rem_ctl_t     ctl,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output rem_sts_t          sts
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]  rem_r;
  logic [W-1:0]  rem_nxt;
  logic [W-1:0]  dvd_r;
  logic [W-1:0]  dsr_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // Shift next dividend bit in, subtract if it fits
  always_comb begin
    trial   = {rem_r, dvd_r[W-1]};
    diff    = trial - {1'b0, dsr_r};
    rem_nxt = diff[W] ? trial[W-1:0] : diff[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start && !busy_r) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_r << 1;
    end
  end

  assign sts = '{busy: busy_r, done: done_r, zero: (rem_r == '0)};

endmodule
`default_nettype wire

// File: rtl/trial_division_prime_test.sv
// Top level of the trial-division prime test: sequencer, bounds and stream ports.
//
// Usage:
//  - Input stream (in_*): one transaction carries a 16-bit unsigned candidate in
//    in_tdata. Only the low VALUE_WIDTH bits are tested (VALUE_WIDTH 2..32,
//    widths above 16 behave as 16).
//  - Result stream (out_*): one transaction per candidate; out_tdata[0] is 1
//    when the candidate is prime. Upper tdata bits are zero.
//  - Divisors 2, 3, ... are tried while d*d <= candidate; d*d is kept by
//    adding 2d+1 per step, so no multiplier is needed.
//  - Each divisor goes through the bound check, the start handshake and
//    one shared bit-serial remainder unit that is NW = min(VALUE_WIDTH, 16)
//    bits wide.
//  - Latency depends on the candidate: the search ends at n < 2, when d*d
//    exceeds n or when a divisor divides n. The search loop sets the rate.
//  - in_tready is high only while no candidate is in progress; one item at a
//    time. A finished result is parked in the output register; if the
//    receiver stalls, the block holds in its done state and takes no new
//    transaction until the result slot frees.
//  - Reset (synchronous, active low) drops any item in progress and clears
//    out_tvalid. Nothing is kept between items.
`timescale 1ns / 1ps
`default_nettype none
module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [CAND_WIDTH-1:0]  in_tdata,   // [15:0] candidate
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_TDATA_W-1:0] out_tdata   // [0] is_prime, [7:1] zero
);

  // Tested width: the candidate field never carries more than CAND_WIDTH bits
  localparam int NW = (VALUE_WIDTH < CAND_WIDTH) ? VALUE_WIDTH : CAND_WIDTH;
  // Square register: (floor(sqrt(n)) + 1)^2 stays below 2^(NW+2)
  localparam int SW = NW + 2;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [NW-1:0] n_r;
  logic [NW-1:0] d_r, d_nxt;
  logic [SW-1:0] sq_r, sq_nxt;
  logic          res_r, res_nxt;
  logic          out_valid_r;
  logic          out_bit_r;
  logic          in_acc;
  logic          out_load;
  logic          n_small;
  logic          sq_over;
  rem_ctl_t      rem_ctl;
  rem_sts_t      rem_sts;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign n_small   = (n_r < NW'(2));
  assign sq_over   = (sq_r > SW'(n_r));
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Sequencer: bound check, divide, test remainder, next divisor
  always_comb begin
    state_nxt     = state_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    res_nxt       = res_r;
    rem_ctl.start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CHECK;
          d_nxt     = NW'(2);
          sq_nxt    = SW'(4);
        end
      end
      ST_CHECK: begin
        if (n_small) begin
          res_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end else if (sq_over) begin
          res_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          rem_ctl.start = 1'b1;
          state_nxt     = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (rem_sts.done) begin
          if (rem_sts.zero) begin
            res_nxt   = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_nxt    = sq_r + SW'({d_r, 1'b1});
            d_nxt     = d_r + 1'b1;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      n_r <= in_tdata[NW-1:0];
    end
    d_r   <= d_nxt;
    sq_r  <= sq_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_bit_r <= res_r;
    end
  end

  tdpt_rem #(
    .W (NW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rem_ctl),
    .dividend (n_r),
    .divisor  (d_r),
    .sts      (rem_sts)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 1){1'b0}}, out_bit_r};

  // Divider is only started when idle
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rem_ctl.start |-> !rem_sts.busy)
    else $error("remainder unit started while busy");

  // Trial divisors are never below two
  a_div_min: assert property (@(posedge clk) disable iff (!rst_n)
    rem_ctl.start |-> (d_r >= NW'(2)))
    else $error("trial divisor below two");

  // A remainder only arrives while the sequencer waits for it
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rem_sts.done |-> (state_r == ST_WAIT))
    else $error("remainder done outside wait state");

  // Incremental square tracks the divisor
  a_sq_track: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> (sq_r == SW'(d_r) * SW'(d_r)))
    else $error("square register out of step with divisor");

  // A result is loaded only from the done state into a free slot
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> !$past(out_load))
    else $error("result slot overwritten while stalled");

endmodule
`default_nettype wire
